// ===== hw/rtl/mec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_pkg
// Shared types, codes and check functions for the Mendelian error counter.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int CHROM_COUNT = 32;
  localparam int COUNT_BITS  = 32;
  localparam int CALL_BITS   = 3;
  localparam int CHROM_BITS  = 5;
  localparam int TOTAL_BITS  = 32;
  localparam int MODE_BITS   = 2;

  localparam int IDX_BITS       = (CHROM_COUNT > 1) ? $clog2(CHROM_COUNT) : 1;
  localparam int CHROM_EXT_BITS = ((IDX_BITS > CHROM_BITS) ? IDX_BITS : CHROM_BITS) + 1;

  typedef logic signed [CALL_BITS-1:0] call_t;
  typedef logic [CHROM_BITS-1:0]       chrom_t;
  typedef logic [TOTAL_BITS-1:0]       total_t;
  typedef logic [MODE_BITS-1:0]        mode_t;
  typedef logic [COUNT_BITS-1:0]       count_t;
  typedef logic [IDX_BITS-1:0]         idx_t;

  // one counter set per chromosome, kept as a single memory word
  typedef struct packed {
    count_t markers;
    count_t trio;
    count_t maternal;
    count_t paternal;
  } counts_t;

  localparam call_t CALL_AA = 3'sd0;
  localparam call_t CALL_AB = 3'sd1;
  localparam call_t CALL_BB = 3'sd2;

  localparam mode_t MODE_TRIO   = 2'd0;
  localparam mode_t MODE_MOTHER = 2'd1;
  localparam mode_t MODE_FATHER = 2'd2;
  localparam mode_t MODE_NONE   = 2'd3;

  function automatic logic duo_error(input call_t child, input call_t parent);
    return (parent == CALL_AA && child == CALL_BB) ||
           (parent == CALL_BB && child == CALL_AA);
  endfunction

  function automatic logic trio_error(input call_t c, input call_t m, input call_t f);
    logic err;
    err = 1'b0;
    if (m == CALL_AA && f == CALL_AA) err = (c == CALL_AB) || (c == CALL_BB);
    if (m == CALL_AA && f == CALL_BB) err = (c == CALL_AA) || (c == CALL_BB);
    if (m == CALL_AA && f == CALL_AB) err = (c == CALL_BB);
    if (m == CALL_AB && f == CALL_AA) err = (c == CALL_BB);
    if (m == CALL_AB && f == CALL_BB) err = (c == CALL_AA);
    if (m == CALL_BB && f == CALL_AB) err = (c == CALL_AA);
    if (m == CALL_BB && f == CALL_AA) err = (c == CALL_AA) || (c == CALL_BB);
    if (m == CALL_BB && f == CALL_BB) err = (c == CALL_AA) || (c == CALL_AB);
    return err;
  endfunction

  function automatic count_t sat_inc(input count_t c);
    return (c == {COUNT_BITS{1'b1}}) ? c : c + COUNT_BITS'(1);
  endfunction

endpackage

// ===== hw/rtl/mec_marker_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_marker_if
// Marker channel: child, mother and father calls plus chromosome number.
// ----------------------------------------------------------------------------
interface mec_marker_if;
  import mec_pkg::*;

  logic   valid;
  logic   ready;
  call_t  child_call;
  call_t  mother_call;
  call_t  father_call;
  chrom_t chromosome;

  modport source (output valid, child_call, mother_call, father_call, chromosome,
                  input ready);
  modport sink   (input valid, child_call, mother_call, father_call, chromosome,
                  output ready);
endinterface

// ===== hw/rtl/mec_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_result_if
// Result channel: error flags and updated per-chromosome totals.
// ----------------------------------------------------------------------------
interface mec_result_if;
  import mec_pkg::*;

  logic   valid;
  logic   ready;
  logic   trio_error;
  logic   maternal_error;
  logic   paternal_error;
  total_t marker_total;
  total_t trio_total;
  total_t maternal_total;
  total_t paternal_total;

  modport source (output valid, trio_error, maternal_error, paternal_error,
                  marker_total, trio_total, maternal_total, paternal_total,
                  input ready);
  modport sink   (input valid, trio_error, maternal_error, paternal_error,
                  marker_total, trio_total, maternal_total, paternal_total,
                  output ready);
endinterface

// ===== hw/rtl/mendelian_error_counter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mendelian_error_counter_core
// Checks each marker against the trio and duo inheritance tables and keeps
// saturating per-chromosome counts in a read-modify-write counter memory.
// ----------------------------------------------------------------------------
//  channel       dir   handshake      payload
//  marker        in    valid/ready    child/mother/father call, chromosome
//  result        out   valid/ready    three error flags, four totals
//  family_mode   in    family_mode_we 2-bit mode, write only
//
//  one item per cycle sustained while result is not stalled; items pass stage 1, then the output register
//  counter memory read is registered into stage 1, the write lands as the item leaves stage 1
//  back-to-back items on the same chromosome take the forwarded counter set
//  rst clears per-entry valid bits at once, so no clearing pass is needed
//  a stalled result holds stage 1; marker ready drops only when both are full
// ----------------------------------------------------------------------------
module mendelian_error_counter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               family_mode_we,
  input  mec_pkg::mode_t     family_mode_wdata,
  mec_marker_if.sink         marker,
  mec_result_if.source       result
);
  import mec_pkg::*;

  mode_t family_mode;

  // counter memory and per-entry valid bits
  counts_t                 mem [CHROM_COUNT];
  logic [CHROM_COUNT-1:0]  ent_valid;

  // stage 1
  logic    s1_valid;
  idx_t    s1_idx;
  logic    s1_in_range;
  logic    s1_count;
  logic    s1_t_err;
  logic    s1_m_err;
  logic    s1_f_err;
  logic    s1_fwd;
  counts_t rd_data;
  logic    rd_vld;
  counts_t last_wr;

  logic                      in_fire;
  logic                      s1_adv;
  logic                      wr_en;
  logic [CHROM_EXT_BITS-1:0] chrom_ext;
  idx_t                      in_idx;
  logic                      in_range;
  logic                      use_m;
  logic                      use_f;
  counts_t                   cur;
  counts_t                   upd;

  assign s1_adv       = s1_valid && (!result.valid || result.ready);
  assign marker.ready = !s1_valid || s1_adv;
  assign in_fire      = marker.valid && marker.ready;

  assign chrom_ext = CHROM_EXT_BITS'(marker.chromosome);
  assign in_idx    = chrom_ext[IDX_BITS-1:0];
  assign in_range  = chrom_ext < CHROM_EXT_BITS'(CHROM_COUNT);

  assign use_m = (family_mode == MODE_TRIO) || (family_mode == MODE_MOTHER);
  assign use_f = (family_mode == MODE_TRIO) || (family_mode == MODE_FATHER);

  assign wr_en = s1_adv && s1_in_range && s1_count;

  always_comb begin
    if (s1_fwd) begin
      cur = last_wr;
    end else if (rd_vld) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
    upd = cur;
    if (s1_count) begin
      upd.markers = sat_inc(cur.markers);
      if (s1_t_err) upd.trio     = sat_inc(cur.trio);
      if (s1_m_err) upd.maternal = sat_inc(cur.maternal);
      if (s1_f_err) upd.paternal = sat_inc(cur.paternal);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      family_mode <= MODE_TRIO;
    end else if (family_mode_we) begin
      family_mode <= family_mode_wdata;
    end
  end

  // memory read and write ports
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data <= mem[in_idx];
    end
    if (wr_en) begin
      mem[s1_idx] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (wr_en) begin
      ent_valid[s1_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx      <= in_idx;
      s1_in_range <= in_range;
      s1_count    <= (family_mode != MODE_NONE);
      s1_t_err    <= (family_mode == MODE_TRIO) &&
                     trio_error(marker.child_call, marker.mother_call, marker.father_call);
      s1_m_err    <= use_m && duo_error(marker.child_call, marker.mother_call);
      s1_f_err    <= use_f && duo_error(marker.child_call, marker.father_call);
      rd_vld      <= ent_valid[in_idx];
      // the write of the item ahead lands on the same edge as this read
      s1_fwd      <= wr_en && (s1_idx == in_idx);
    end
    if (wr_en) begin
      last_wr <= upd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.trio_error     <= s1_t_err;
      result.maternal_error <= s1_m_err;
      result.paternal_error <= s1_f_err;
      if (s1_in_range) begin
        result.marker_total   <= TOTAL_BITS'(upd.markers);
        result.trio_total     <= TOTAL_BITS'(upd.trio);
        result.maternal_total <= TOTAL_BITS'(upd.maternal);
        result.paternal_total <= TOTAL_BITS'(upd.paternal);
      end else begin
        result.marker_total   <= '0;
        result.trio_total     <= '0;
        result.maternal_total <= '0;
        result.paternal_total <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_reset_clears_valid: assert property (@(posedge clk)
    $past(rst) |-> (ent_valid == '0))
    else $error("valid bits not cleared after reset");

  a_none_no_flags: assert property (@(posedge clk) disable iff (rst)
    (result.valid && family_mode == MODE_NONE) |->
      (!result.trio_error && !result.maternal_error && !result.paternal_error))
    else $error("error flag raised with no parents");

  a_errors_within_markers: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.marker_total >= result.trio_total &&
                      result.marker_total >= result.maternal_total &&
                      result.marker_total >= result.paternal_total))
    else $error("error total exceeds marker total");

  a_flag_counted: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.trio_error && result.marker_total != '0) |->
      (result.trio_total != '0))
    else $error("trio error flagged but not counted");
`endif

endmodule
